@@ hw/rtl/tvss_pkg.sv @@
// Package for the three-voice square sound generator.
// Holds the item type, the voice constants and the mixing function.
// No dependencies.
`default_nettype none

package tvss_pkg;

    localparam int NUM_VOICES  = 3;
    localparam int PERIOD_W    = 6;
    localparam int COUNT_W     = 7;
    localparam int CHANNEL_W   = 2;
    localparam int DATA_W      = 8;
    localparam int SAMPLE_W    = 15;
    localparam int ACC_W       = SAMPLE_W + 1;
    localparam int WEIGHT_SCALE = 256;
    localparam int CTRL_ENABLE_BIT = 1;

    localparam logic [COUNT_W-1:0]   COUNT_LIMIT = COUNT_W'(64);
    localparam logic [CHANNEL_W-1:0] CH_CONTROL  = CHANNEL_W'(3);

    localparam logic signed [ACC_W-1:0] VOICE_WEIGHT [NUM_VOICES] = '{
        ACC_W'(16'h10 * WEIGHT_SCALE),
        ACC_W'(16'h18 * WEIGHT_SCALE),
        ACC_W'(16'h20 * WEIGHT_SCALE)
    };
    localparam logic signed [ACC_W-1:0] MIX_OFFSET =
        ACC_W'((16'h10 + 16'h18 + 16'h20) * (WEIGHT_SCALE / 2));

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [CHANNEL_W-1:0] channel;
        logic [DATA_W-1:0]    write_data;
    } t_item;

    function automatic logic signed [SAMPLE_W-1:0] mix(input logic [NUM_VOICES-1:0] levels);
        logic signed [ACC_W-1:0] acc;
        acc = -MIX_OFFSET;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (levels[v]) begin
                acc = acc + VOICE_WEIGHT[v];
            end
        end
        return acc[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tvss_voices.sv @@
// Voice state of the square sound generator: periods, counters, levels,
// control byte and the mixed sample. Uses tvss_pkg.
`default_nettype none

module tvss_voices (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire tvss_pkg::t_item                   i_item,
    output logic signed [tvss_pkg::SAMPLE_W-1:0]   o_sample
);

    logic [tvss_pkg::PERIOD_W-1:0] r_period [tvss_pkg::NUM_VOICES];
    logic [tvss_pkg::PERIOD_W-1:0] n_period [tvss_pkg::NUM_VOICES];
    logic [tvss_pkg::COUNT_W-1:0]  r_count  [tvss_pkg::NUM_VOICES];
    logic [tvss_pkg::COUNT_W-1:0]  n_count  [tvss_pkg::NUM_VOICES];
    logic [tvss_pkg::NUM_VOICES-1:0] r_level, n_level;
    logic [tvss_pkg::DATA_W-1:0]   r_control, n_control;
    logic signed [tvss_pkg::SAMPLE_W-1:0] r_sample, n_sample;

    always_comb begin
        logic [tvss_pkg::PERIOD_W-1:0] per;
        logic [tvss_pkg::COUNT_W-1:0]  cnt;
        n_period  = r_period;
        n_count   = r_count;
        n_level   = r_level;
        n_control = r_control;
        n_sample  = r_sample;
        per = '0;
        cnt = '0;
        for (int v = 0; v < tvss_pkg::NUM_VOICES; v++) begin
            if (i_item.op == tvss_pkg::OP_WRITE) begin
                if (i_item.channel == tvss_pkg::CHANNEL_W'(v)) begin
                    per = ~i_item.write_data[tvss_pkg::PERIOD_W-1:0];
                    if (per == '0 && r_period[v] != '0) begin
                        n_level[v] = ~r_level[v];
                    end
                    n_period[v] = per;
                end
            end else begin
                cnt = (r_count[v] < tvss_pkg::COUNT_LIMIT) ? r_count[v] + 1'b1 : r_count[v];
                if (r_period[v] != '0 && cnt >= {1'b0, r_period[v]}) begin
                    n_count[v] = '0;
                    n_level[v] = ~r_level[v];
                end else begin
                    n_count[v] = cnt;
                end
            end
        end
        if (i_item.op == tvss_pkg::OP_WRITE) begin
            if (i_item.channel == tvss_pkg::CH_CONTROL) begin
                n_control = i_item.write_data;
            end
        end else begin
            n_sample = r_control[tvss_pkg::CTRL_ENABLE_BIT] ? tvss_pkg::mix(n_level) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < tvss_pkg::NUM_VOICES; v++) begin
                r_period[v] <= '0;
                r_count[v]  <= '0;
            end
            r_level   <= '1;
            r_control <= '0;
            r_sample  <= '0;
        end else if (i_accept) begin
            r_period  <= n_period;
            r_count   <= n_count;
            r_level   <= n_level;
            r_control <= n_control;
            r_sample  <= n_sample;
        end
    end

    assign o_sample = n_sample;

endmodule

`default_nettype wire

@@ hw/rtl/three_voice_square_sound.sv @@
// Three-voice square-wave sound generator. Each item is a port write
// (channels 0-2 load a voice period with the inverted data, channel 3 the
// control byte) or one sound-clock tick, and yields one mixed sample. One
// item is taken every clock cycle while the skid stage is empty; its sample
// is held in an output register, backed by a one-entry skid stage so that
// one more item is taken while the output is stalled. Uses tvss_pkg, tvss_voices.
`default_nettype none

module three_voice_square_sound (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_op,
    input  wire logic [tvss_pkg::CHANNEL_W-1:0]         i_channel,
    input  wire logic [tvss_pkg::DATA_W-1:0]            i_write_data,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [tvss_pkg::SAMPLE_W-1:0]        o_sample
);

    tvss_pkg::t_item item;
    logic accept, out_take;
    logic signed [tvss_pkg::SAMPLE_W-1:0] new_sample;
    logic r_out_valid, r_skid_valid;
    logic signed [tvss_pkg::SAMPLE_W-1:0] r_out_sample, r_skid_sample;

    assign item.op         = tvss_pkg::t_op'(i_op);
    assign item.channel    = i_channel;
    assign item.write_data = i_write_data;

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    tvss_voices u_voices (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_sample (new_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_sample <= r_skid_sample;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || out_take) begin
                r_out_sample <= new_sample;
                r_out_valid  <= 1'b1;
            end else begin
                r_skid_sample <= new_sample;
                r_skid_valid  <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

endmodule

`default_nettype wire

@@ hw/rtl/tvss_checker.sv @@
// Port-level checks for the three-voice square sound generator.
// Bound to three_voice_square_sound; uses tvss_pkg.
`default_nettype none

module tvss_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_valid,
    input wire logic                                   o_stall,
    input wire logic                                   o_valid,
    input wire logic                                   i_stall,
    input wire logic signed [tvss_pkg::SAMPLE_W-1:0]   o_sample
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample))
        else $error("stalled output item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample >= -15'sd9216 && o_sample <= 15'sd9216))
        else $error("sample out of range");

    a_accept_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted item gave no output");

endmodule

bind three_voice_square_sound tvss_checker u_tvss_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_sample (o_sample)
);

`default_nettype wire

@@ tb/three_voice_square_sound_tb.sv @@
// Testbench for three_voice_square_sound: port writes and sound ticks go in through
// valid/stall, and each sample is checked against a local model of the three voices.
// Depends on tvss_pkg and the three_voice_square_sound top level.
`timescale 1ns / 1ps

module three_voice_square_sound_tb;

    localparam int RUN_ITEMS   = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 60;
    localparam int SAT_TICKS   = 80;

    localparam logic [tvss_pkg::CHANNEL_W-1:0] CH_VOICE0 = 2'd0;
    localparam logic [tvss_pkg::CHANNEL_W-1:0] CH_VOICE1 = 2'd1;
    localparam logic [tvss_pkg::CHANNEL_W-1:0] CH_VOICE2 = 2'd2;

    localparam int GAIN0  = 'h10 * 256;
    localparam int GAIN1  = 'h18 * 256;
    localparam int GAIN2  = 'h20 * 256;
    localparam int CENTRE = ('h10 + 'h18 + 'h20) * 128;

    typedef struct packed {
        tvss_pkg::t_op                        op;
        logic [tvss_pkg::CHANNEL_W-1:0]       channel;
        logic [tvss_pkg::DATA_W-1:0]          write_data;
        logic                                 fixed;
        logic signed [tvss_pkg::SAMPLE_W-1:0] level;
    } t_dir_row;

    logic                                  i_clk        = 1'b0;
    logic                                  i_rst_n      = 1'b0;
    logic                                  i_valid      = 1'b0;
    logic                                  o_stall;
    logic                                  i_op         = 1'b0;
    logic [tvss_pkg::CHANNEL_W-1:0]        i_channel    = '0;
    logic [tvss_pkg::DATA_W-1:0]           i_write_data = '0;
    logic                                  o_valid;
    logic                                  i_stall      = 1'b0;
    logic signed [tvss_pkg::SAMPLE_W-1:0]  o_sample;

    logic [tvss_pkg::PERIOD_W-1:0]         voice_per [tvss_pkg::NUM_VOICES];
    logic [tvss_pkg::COUNT_W-1:0]          voice_cnt [tvss_pkg::NUM_VOICES];
    logic [tvss_pkg::NUM_VOICES-1:0]       voice_lvl;
    logic [tvss_pkg::DATA_W-1:0]           ctrl_reg;
    logic signed [tvss_pkg::SAMPLE_W-1:0]  held_sample;

    logic signed [tvss_pkg::SAMPLE_W-1:0]  expected_samples [$];
    logic                                  fixed_on   = 1'b0;
    logic signed [tvss_pkg::SAMPLE_W-1:0]  fixed_val  = '0;
    int                                    errors     = 0;
    int                                    cycles     = 0;
    int                                    tx_max     = 10;
    int                                    rx_max     = 10;
    int                                    hold_req   = 0;

    three_voice_square_sound DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_channel    (i_channel),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [tvss_pkg::SAMPLE_W-1:0] mix_after_item(
        input tvss_pkg::t_op                  op,
        input logic [tvss_pkg::CHANNEL_W-1:0] ch,
        input logic [tvss_pkg::DATA_W-1:0]    data
    );
        logic [tvss_pkg::PERIOD_W-1:0] per;
        int                            acc;
        int                            v;
        if (op == tvss_pkg::OP_WRITE) begin
            if (ch == tvss_pkg::CH_CONTROL) begin
                ctrl_reg = data;
            end else begin
                per = ~data[tvss_pkg::PERIOD_W-1:0];
                if (per == '0 && voice_per[ch] != '0) begin
                    voice_lvl[ch] = ~voice_lvl[ch];
                end
                voice_per[ch] = per;
            end
        end else begin
            for (v = 0; v < tvss_pkg::NUM_VOICES; v++) begin
                if (voice_cnt[v] < tvss_pkg::COUNT_LIMIT) begin
                    voice_cnt[v] = voice_cnt[v] + 1'b1;
                end
                if (voice_per[v] != '0 &&
                    voice_cnt[v] >= tvss_pkg::COUNT_W'(voice_per[v])) begin
                    voice_cnt[v] = '0;
                    voice_lvl[v] = ~voice_lvl[v];
                end
            end
            if (!ctrl_reg[tvss_pkg::CTRL_ENABLE_BIT]) begin
                held_sample = '0;
            end else begin
                acc = -CENTRE;
                if (voice_lvl[0]) acc += GAIN0;
                if (voice_lvl[1]) acc += GAIN1;
                if (voice_lvl[2]) acc += GAIN2;
                held_sample = acc[tvss_pkg::SAMPLE_W-1:0];
            end
        end
        return held_sample;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        logic signed [tvss_pkg::SAMPLE_W-1:0] want;
        logic signed [tvss_pkg::SAMPLE_W-1:0] model;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                model = mix_after_item(tvss_pkg::t_op'(i_op), i_channel, i_write_data);
                expected_samples.insert(expected_samples.size(),
                                        fixed_on ? fixed_val : model);
            end
            if (o_valid && !i_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("sample: no item expected, got %0d", o_sample);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample !== want) begin
                        $error("sample: expected %0d, got %0d", want, o_sample);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : receiver
        int n;
        int holds_done;
        holds_done = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req != holds_done) begin
                holds_done = hold_req;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            n = $urandom_range(0, rx_max);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_item(
        input tvss_pkg::t_op                        op,
        input logic [tvss_pkg::CHANNEL_W-1:0]       ch,
        input logic [tvss_pkg::DATA_W-1:0]          data,
        input logic                                 fixed,
        input logic signed [tvss_pkg::SAMPLE_W-1:0] level
    );
        int n;
        n = $urandom_range(0, tx_max);
        @(negedge i_clk);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_channel    <= ch;
        i_write_data <= data;
        fixed_on     <= fixed;
        fixed_val    <= level;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random();
        tvss_pkg::t_op                  op;
        logic [tvss_pkg::CHANNEL_W-1:0] ch;
        logic [tvss_pkg::DATA_W-1:0]    data;
        int                             pick;
        op   = ($urandom_range(0, 99) < 60) ? tvss_pkg::OP_TICK : tvss_pkg::OP_WRITE;
        ch   = tvss_pkg::CHANNEL_W'($urandom_range(0, 3));
        data = tvss_pkg::DATA_W'($urandom);
        pick = $urandom_range(0, 9);
        if (ch == tvss_pkg::CH_CONTROL) begin
            if (pick < 8) data[tvss_pkg::CTRL_ENABLE_BIT] = 1'b1;
        end else if (pick < 3) begin
            data[tvss_pkg::PERIOD_W-1:0] = '1;
        end else if (pick < 7) begin
            data[tvss_pkg::PERIOD_W-1:0] = ~tvss_pkg::PERIOD_W'($urandom_range(1, 6));
        end
        send_item(op, ch, data, 1'b0, '0);
    endtask

    // Stop the voices, let the counters run into their limit, then restart them.
    task automatic run_saturation();
        send_item(tvss_pkg::OP_WRITE, CH_VOICE0, 8'hFF, 1'b0, '0);
        send_item(tvss_pkg::OP_WRITE, CH_VOICE1, 8'hFF, 1'b0, '0);
        send_item(tvss_pkg::OP_WRITE, CH_VOICE2, 8'hFF, 1'b0, '0);
        repeat (SAT_TICKS) begin
            send_item(tvss_pkg::OP_TICK, CH_VOICE0, tvss_pkg::DATA_W'($urandom), 1'b0, '0);
        end
        send_item(tvss_pkg::OP_WRITE, CH_VOICE0, 8'hC0, 1'b0, '0);
        send_item(tvss_pkg::OP_WRITE, CH_VOICE1, 8'hFE, 1'b0, '0);
        send_item(tvss_pkg::OP_WRITE, CH_VOICE2, 8'hDF, 1'b0, '0);
        repeat (3) begin
            send_item(tvss_pkg::OP_TICK, tvss_pkg::CH_CONTROL,
                      tvss_pkg::DATA_W'($urandom), 1'b0, '0);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_dir_row dir_tab [24];
        int       v;
        int       phase;
        int       sent;

        for (v = 0; v < tvss_pkg::NUM_VOICES; v++) begin
            voice_per[v] = '0;
            voice_cnt[v] = '0;
        end
        voice_lvl   = '1;
        ctrl_reg    = '0;
        held_sample = '0;

        dir_tab[0]  = '{tvss_pkg::OP_WRITE, CH_VOICE0,  8'hFF, 1'b1, 15'sd0};
        dir_tab[1]  = '{tvss_pkg::OP_TICK,  CH_VOICE0,  8'h00, 1'b1, 15'sd0};
        dir_tab[2]  = '{tvss_pkg::OP_WRITE, tvss_pkg::CH_CONTROL, 8'h02, 1'b1, 15'sd0};
        dir_tab[3]  = '{tvss_pkg::OP_TICK,  CH_VOICE1,  8'hFF, 1'b1, 15'sd9216};
        dir_tab[4]  = '{tvss_pkg::OP_WRITE, CH_VOICE0,  8'h00, 1'b1, 15'sd9216};
        dir_tab[5]  = '{tvss_pkg::OP_WRITE, CH_VOICE0,  8'hFF, 1'b1, 15'sd9216};
        dir_tab[6]  = '{tvss_pkg::OP_TICK,  CH_VOICE2,  8'h55, 1'b1, 15'sd5120};
        dir_tab[7]  = '{tvss_pkg::OP_WRITE, CH_VOICE1,  8'hC0, 1'b0, 15'sd0};
        dir_tab[8]  = '{tvss_pkg::OP_WRITE, CH_VOICE1,  8'hFF, 1'b0, 15'sd0};
        dir_tab[9]  = '{tvss_pkg::OP_WRITE, CH_VOICE2,  8'h3E, 1'b0, 15'sd0};
        dir_tab[10] = '{tvss_pkg::OP_TICK,  tvss_pkg::CH_CONTROL, 8'hAA, 1'b0, 15'sd0};
        dir_tab[11] = '{tvss_pkg::OP_WRITE, tvss_pkg::CH_CONTROL, 8'h03, 1'b0, 15'sd0};
        dir_tab[12] = '{tvss_pkg::OP_TICK,  CH_VOICE0,  8'h00, 1'b0, 15'sd0};
        dir_tab[13] = '{tvss_pkg::OP_WRITE, tvss_pkg::CH_CONTROL, 8'hFD, 1'b0, 15'sd0};
        dir_tab[14] = '{tvss_pkg::OP_TICK,  CH_VOICE0,  8'hFF, 1'b1, 15'sd0};
        dir_tab[15] = '{tvss_pkg::OP_WRITE, tvss_pkg::CH_CONTROL, 8'hFF, 1'b0, 15'sd0};
        dir_tab[16] = '{tvss_pkg::OP_TICK,  CH_VOICE1,  8'h00, 1'b0, 15'sd0};
        dir_tab[17] = '{tvss_pkg::OP_WRITE, CH_VOICE2,  8'h00, 1'b0, 15'sd0};
        dir_tab[18] = '{tvss_pkg::OP_TICK,  CH_VOICE2,  8'hFF, 1'b0, 15'sd0};
        dir_tab[19] = '{tvss_pkg::OP_WRITE, CH_VOICE0,  8'h40, 1'b0, 15'sd0};
        dir_tab[20] = '{tvss_pkg::OP_TICK,  CH_VOICE0,  8'h00, 1'b0, 15'sd0};
        dir_tab[21] = '{tvss_pkg::OP_WRITE, CH_VOICE1,  8'h7E, 1'b0, 15'sd0};
        dir_tab[22] = '{tvss_pkg::OP_TICK,  CH_VOICE1,  8'hFF, 1'b0, 15'sd0};
        dir_tab[23] = '{tvss_pkg::OP_TICK,  tvss_pkg::CH_CONTROL, 8'h00, 1'b0, 15'sd0};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            send_item(dir_tab[k].op, dir_tab[k].channel, dir_tab[k].write_data,
                      dir_tab[k].fixed, dir_tab[k].level);
        end

        // Hold the output off while items keep coming, so the input backs up.
        tx_max   = 0;
        hold_req = hold_req + 1;
        repeat (30) send_random();
        tx_max = 10;
        drain();
        run_saturation();

        sent  = 0;
        phase = 0;
        while (sent < RUN_ITEMS) begin
            case (phase % 4)
                0: begin
                    tx_max = 10;
                    rx_max = 10;
                end
                1: begin
                    tx_max = 0;
                    rx_max = 0;
                end
                2: begin
                    tx_max = 0;
                    rx_max = 10;
                end
                default: begin
                    tx_max = 10;
                    rx_max = 0;
                end
            endcase
            repeat (100) send_random();
            sent += 100;
            if (phase % 5 == 4) begin
                run_saturation();
                sent += SAT_TICKS + 9;
            end
            if (phase % 3 == 2) drain();
            phase++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tvss_pkg.sv
hw/rtl/tvss_voices.sv
hw/rtl/three_voice_square_sound.sv
hw/rtl/tvss_checker.sv
tb/three_voice_square_sound_tb.sv
